>>> sv/large_page_table_manager_macros.svh
// assertion macros shared by the page table manager rtl
`ifndef LARGE_PAGE_TABLE_MANAGER_MACROS_SVH
`define LARGE_PAGE_TABLE_MANAGER_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define LPTM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define LPTM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/lptm_pkg.sv
// types and constants of the large page table manager
package lptm_pkg;

  localparam int unsigned REGION_COUNT = 4;
  localparam int unsigned PAGE_W       = 21;
  localparam int unsigned IDX_W        = 9;
  localparam int unsigned REGION_W     = (REGION_COUNT > 1) ? $clog2(REGION_COUNT) : 1;
  localparam int unsigned SLOT_W       = IDX_W + REGION_W;
  localparam int unsigned DEPTH        = REGION_COUNT * 512;
  localparam int unsigned CLR_W        = $clog2(DEPTH + 1);
  localparam int unsigned FRAME_W      = IDX_W + $clog2(REGION_COUNT);
  localparam int unsigned REGION_LSB   = 30;
  localparam logic [63:0] SPAN         = 64'(REGION_COUNT) << REGION_LSB;

  // x86 large-page descriptor bit positions
  localparam int unsigned D_PRESENT = 0;
  localparam int unsigned D_WRITE   = 1;
  localparam int unsigned D_USER    = 2;
  localparam int unsigned D_PWT     = 3;
  localparam int unsigned D_PCD     = 4;
  localparam int unsigned D_LARGE   = 7;
  localparam int unsigned D_GLOBAL  = 8;
  localparam int unsigned D_NX      = 63;

  typedef enum logic [1:0] {
    MODE_MAP       = 2'd0,
    MODE_UNMAP     = 2'd1,
    MODE_PROTECT   = 2'd2,
    MODE_TRANSLATE = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_INVAL     = 3'd1,
    ST_NOSUP     = 3'd2,
    ST_FAULT     = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

  // compact stored form of one descriptor
  typedef struct packed {
    logic               present;
    logic [FRAME_W-1:0] frame;
    logic               write;
    logic               user;
    logic               glob;
    logic               device;
    logic               exec;
  } entry_t;

  typedef struct packed {
    logic              re;
    logic [SLOT_W-1:0] addr;
  } rd_req_t;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] addr;
    entry_t            data;
  } wr_req_t;

endpackage

>>> sv/lptm_if.sv
// request and response channel interfaces
interface lptm_req_if import lptm_pkg::*; ();
  logic        valid;
  logic        ready;
  mode_e       mode;
  logic [63:0] virt_addr;
  logic [63:0] phys_addr_in;
  logic        want_write;
  logic        want_user;
  logic        want_global;
  logic        want_device;
  logic        want_exec;

  modport source (
    output valid, mode, virt_addr, phys_addr_in,
    output want_write, want_user, want_global, want_device, want_exec,
    input  ready
  );
  modport sink (
    input  valid, mode, virt_addr, phys_addr_in,
    input  want_write, want_user, want_global, want_device, want_exec,
    output ready
  );
endinterface

interface lptm_rsp_if import lptm_pkg::*; ();
  logic        valid;
  logic        ready;
  status_e     status;
  logic [31:0] phys_addr_out;
  logic [63:0] raw_descriptor;
  logic        can_write;
  logic        is_user;
  logic        is_global;
  logic        is_device;
  logic        can_exec;
  logic        root_user_mark;
  logic        region_user_mark;

  modport source (
    output valid, status, phys_addr_out, raw_descriptor,
    output can_write, is_user, is_global, is_device, can_exec,
    output root_user_mark, region_user_mark,
    input  ready
  );
  modport sink (
    input  valid, status, phys_addr_out, raw_descriptor,
    input  can_write, is_user, is_global, is_device, can_exec,
    input  root_user_mark, region_user_mark,
    output ready
  );
endinterface

>>> sv/lptm_store.sv
// descriptor memory with registered read, write forwarding and clear sweep
module lptm_store import lptm_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  rd_req_t rd_i,
  input  wr_req_t wr_i,
  output entry_t  rdata_o,
  output logic    ready_o
);

  entry_t            mem [DEPTH];
  entry_t            rdata_q;
  logic [CLR_W-1:0]  clr_cnt_q, clr_cnt_d;
  logic              clearing;

  assign clearing  = (clr_cnt_q != CLR_W'(DEPTH));
  assign clr_cnt_d = clearing ? clr_cnt_q + CLR_W'(1) : clr_cnt_q;
  assign ready_o   = !clearing;
  assign rdata_o   = rdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else begin
      clr_cnt_q <= clr_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clearing) begin
      mem[clr_cnt_q[SLOT_W-1:0]] <= '0;
    end else if (wr_i.we) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  // a read at the edge of a write to the same slot sees the new entry
  always_ff @(posedge clk_i) begin
    if (rd_i.re) begin
      if (wr_i.we && (wr_i.addr == rd_i.addr)) begin
        rdata_q <= wr_i.data;
      end else begin
        rdata_q <= mem[rd_i.addr];
      end
    end
  end

endmodule

>>> sv/large_page_table_manager.sv
// top level of the large page table manager
//
//  channel  dir  handshake        payload
//  req_i    in   valid / ready    mode, virt_addr, phys_addr_in, want_* flags
//  rsp_o    out  valid / ready    status, phys_addr_out, raw_descriptor, marks
//  cfg      in   cfg_we_i         cfg_wdata_i -> upper_levels_present
//
// a transaction is read from the descriptor memory on acceptance and written
// back when it finishes, as the result is loaded into the output register;
// with rsp_o drained it takes one request per cycle. after reset a sweep
// clears the 2048 memory entries with req_i.ready low. a stalled result
// holds one request in flight, no more.
`include "large_page_table_manager_macros.svh"

module large_page_table_manager import lptm_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  lptm_req_if.sink   req_i,
  lptm_rsp_if.source rsp_o,
  input  logic  cfg_we_i,
  input  logic  cfg_wdata_i
);

  typedef struct packed {
    mode_e       mode;
    logic [63:0] va;
    logic [63:0] pa;
    logic        want_write;
    logic        want_user;
    logic        want_global;
    logic        want_device;
    logic        want_exec;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] phys;
    logic [63:0] desc;
    logic        can_write;
    logic        is_user;
    logic        is_global;
    logic        is_device;
    logic        can_exec;
    logic        root_mark;
    logic        region_mark;
  } rsp_t;

  req_t                    req_q;
  rsp_t                    rsp_q, rsp_d;
  logic                    busy_q, busy_d;
  logic                    rsp_valid_q, rsp_valid_d;
  logic                    upl_q, upl_d;
  logic                    root_user_q, root_user_d;
  logic [REGION_COUNT-1:0] region_user_q, region_user_d;

  rd_req_t rd;
  wr_req_t wr;
  entry_t  ent, new_ent;
  logic    store_ready;
  logic    acc, fin;

  logic                va_misal, pa_misal, va_oor, pa_oor;
  logic                is_map, addressed, set_user;
  logic [REGION_W-1:0] region;
  logic [63:0]         frame64;
  status_e             status;

  lptm_store u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rd_i    (rd),
    .wr_i    (wr),
    .rdata_o (ent),
    .ready_o (store_ready)
  );

  // handshake and control
  assign fin           = busy_q && (!rsp_valid_q || rsp_o.ready);
  assign req_i.ready   = store_ready && (!busy_q || fin);
  assign acc           = req_i.valid && req_i.ready;
  assign busy_d        = acc ? 1'b1 : (fin ? 1'b0 : busy_q);
  assign rsp_valid_d   = fin ? 1'b1 : (rsp_o.ready ? 1'b0 : rsp_valid_q);
  assign upl_d         = cfg_we_i ? cfg_wdata_i : upl_q;

  assign rd.re   = acc;
  assign rd.addr = req_i.virt_addr[PAGE_W +: SLOT_W];

  // request checks in priority order
  always_comb begin
    is_map    = (req_q.mode == MODE_MAP);
    va_misal  = |req_q.va[PAGE_W-1:0];
    pa_misal  = is_map && (|req_q.pa[PAGE_W-1:0]);
    va_oor    = (req_q.va >= SPAN);
    pa_oor    = is_map && (req_q.pa >= SPAN);
    region    = req_q.va[REGION_LSB +: REGION_W];

    if (va_misal || pa_misal) begin
      status = ST_INVAL;
    end else if (va_oor || pa_oor) begin
      status = ST_NOSUP;
    end else if (is_map && !upl_q) begin
      status = ST_FAULT;
    end else if (!is_map && !ent.present) begin
      status = ST_NOT_FOUND;
    end else begin
      status = ST_OK;
    end

    addressed = (status != ST_INVAL) && (status != ST_NOSUP);
    set_user  = addressed && req_q.want_user &&
                ((is_map && upl_q) || (req_q.mode == MODE_PROTECT));
  end

  // write-back of the modified entry
  always_comb begin
    new_ent.present = 1'b1;
    new_ent.frame   = is_map ? req_q.pa[PAGE_W +: FRAME_W] : ent.frame;
    new_ent.write   = req_q.want_write;
    new_ent.user    = req_q.want_user;
    new_ent.glob    = req_q.want_global;
    new_ent.device  = req_q.want_device;
    new_ent.exec    = req_q.want_exec;

    wr.we   = 1'b0;
    wr.addr = req_q.va[PAGE_W +: SLOT_W];
    wr.data = new_ent;
    if (fin && (status == ST_OK)) begin
      case (req_q.mode)
        MODE_MAP: begin
          wr.we = 1'b1;
        end
        MODE_UNMAP: begin
          wr.we   = 1'b1;
          wr.data = '0;
        end
        MODE_PROTECT: begin
          wr.we = 1'b1;
        end
        default: begin
          wr.we = 1'b0;
        end
      endcase
    end
  end

  // user marks
  always_comb begin
    root_user_d   = root_user_q;
    region_user_d = region_user_q;
    if (fin && set_user) begin
      root_user_d           = 1'b1;
      region_user_d[region] = 1'b1;
    end
  end

  // result
  always_comb begin
    frame64           = 64'(ent.frame) << PAGE_W;
    rsp_d             = '0;
    rsp_d.status      = status;
    rsp_d.root_mark   = root_user_q | set_user;
    rsp_d.region_mark = addressed && (region_user_q[region] | set_user);
    if ((req_q.mode == MODE_TRANSLATE) && (status == ST_OK)) begin
      rsp_d.phys              = frame64[31:0];
      rsp_d.desc              = frame64;
      rsp_d.desc[D_PRESENT]   = 1'b1;
      rsp_d.desc[D_WRITE]     = ent.write;
      rsp_d.desc[D_USER]      = ent.user;
      rsp_d.desc[D_PWT]       = ent.device;
      rsp_d.desc[D_PCD]       = ent.device;
      rsp_d.desc[D_LARGE]     = 1'b1;
      rsp_d.desc[D_GLOBAL]    = ent.glob;
      rsp_d.desc[D_NX]        = !ent.exec;
      rsp_d.can_write         = ent.write;
      rsp_d.is_user           = ent.user;
      rsp_d.is_global         = ent.glob;
      rsp_d.is_device         = ent.device;
      rsp_d.can_exec          = ent.exec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q        <= 1'b0;
      rsp_valid_q   <= 1'b0;
      upl_q         <= 1'b1;
      root_user_q   <= 1'b0;
      region_user_q <= '0;
    end else begin
      busy_q        <= busy_d;
      rsp_valid_q   <= rsp_valid_d;
      upl_q         <= upl_d;
      root_user_q   <= root_user_d;
      region_user_q <= region_user_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      req_q.mode        <= req_i.mode;
      req_q.va          <= req_i.virt_addr;
      req_q.pa          <= req_i.phys_addr_in;
      req_q.want_write  <= req_i.want_write;
      req_q.want_user   <= req_i.want_user;
      req_q.want_global <= req_i.want_global;
      req_q.want_device <= req_i.want_device;
      req_q.want_exec   <= req_i.want_exec;
    end
    if (fin) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o.valid            = rsp_valid_q;
  assign rsp_o.status           = rsp_q.status;
  assign rsp_o.phys_addr_out    = rsp_q.phys;
  assign rsp_o.raw_descriptor   = rsp_q.desc;
  assign rsp_o.can_write        = rsp_q.can_write;
  assign rsp_o.is_user          = rsp_q.is_user;
  assign rsp_o.is_global        = rsp_q.is_global;
  assign rsp_o.is_device        = rsp_q.is_device;
  assign rsp_o.can_exec         = rsp_q.can_exec;
  assign rsp_o.root_user_mark   = rsp_q.root_mark;
  assign rsp_o.region_user_mark = rsp_q.region_mark;

  `LPTM_ASSERT_IMP(a_no_accept_clearing, acc, store_ready, "request accepted during clear sweep")
  `LPTM_ASSERT_NXT(a_fin_gives_rsp, fin, rsp_o.valid, "finished request left no response")
  `LPTM_ASSERT_NXT(a_busy_holds, busy_q && !fin, busy_q, "stalled request was dropped")
  `LPTM_ASSERT_IMP(a_wr_only_on_fin, wr.we, fin, "memory written outside a finishing cycle")
  `LPTM_ASSERT_IMP(a_desc_zero_on_err, rsp_o.valid && (rsp_o.status != ST_OK),
                   rsp_o.raw_descriptor == 64'd0, "descriptor nonzero on failed request")

endmodule
